// ----- rtl/plt_pkg.sv -----
// Package for the process lifetime timer block: command and status codes,
// sequencer states and the result record.
// No dependencies; compile first.
`default_nettype none

package plt_pkg;

	// Fixed widths of the channel fields
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned FIELD_W  = 16;
	localparam int unsigned COUNT_W  = 5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd4;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} plt_state_t;

	// One result record as handed to the output register
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  found_id;
		logic [FIELD_W-1:0]  life_left;
		logic [COUNT_W-1:0]  entry_count;
		logic                last;
	} plt_res_t;

endpackage

`default_nettype wire

// ----- rtl/plt_if.sv -----
// Valid/ready channel interfaces for the timer block: command requests and
// result records.
// Depends on plt_pkg.
`default_nettype none

interface plt_req_if;
	import plt_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [FIELD_W-1:0] proc_id;
	logic [FIELD_W-1:0] life_ticks;

	modport source (output valid, output cmd, output proc_id, output life_ticks,
		input ready);
	modport sink (input valid, input cmd, input proc_id, input life_ticks,
		output ready);
endinterface

interface plt_rsp_if;
	import plt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FIELD_W-1:0]  found_id;
	logic [FIELD_W-1:0]  life_left;
	logic [COUNT_W-1:0]  entry_count;
	logic                last;

	modport source (output valid, output status, output found_id, output life_left,
		output entry_count, output last, input ready);
	modport sink (input valid, input status, input found_id, input life_left,
		input entry_count, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/plt_mem.sv -----
// Timer entry store: one synchronous memory of {id, life} words, one write
// port and one read port with registered read data.
// No package dependency.
`default_nettype none

module plt_mem #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4,
	parameter int unsigned ID_W   = 16,
	parameter int unsigned LIFE_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [ID_W-1:0]   wid,
	input  wire logic [LIFE_W-1:0] wlife,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [ID_W-1:0]   rid,
	output logic      [LIFE_W-1:0] rlife
);

	logic [ID_W+LIFE_W-1:0] mem_q [DEPTH];
	logic [ID_W+LIFE_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= {wid, wlife};
		end
	end

	// Read port, registered: data valid in the cycle after the enable
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rid   = rdata_q[ID_W+LIFE_W-1:LIFE_W];
	assign rlife = rdata_q[LIFE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/plt_out.sv -----
// Result output register: holds one result record until the sink takes it
// and reports when a new record can be loaded.
// Depends on plt_pkg and plt_rsp_if.
`default_nettype none

module plt_out (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               emit,
	input  wire plt_pkg::plt_res_t  res,
	output logic                    out_free,
	plt_rsp_if.source               rsp
);
	import plt_pkg::*;

	logic     out_vld_q;
	plt_res_t res_q;
	logic     load;

	// Free when empty or when the held record transfers this cycle
	assign out_free = !out_vld_q || rsp.ready;
	assign load     = emit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = res_q.status;
	assign rsp.found_id    = res_q.found_id;
	assign rsp.life_left   = res_q.life_left;
	assign rsp.entry_count = res_q.entry_count;
	assign rsp.last        = res_q.last;

endmodule

`default_nettype wire

// ----- rtl/plt_ctrl.sv -----
// Command sequencer: takes one command, walks the entry memory with a
// read-modify-write pass (delete, query, tick) and produces result records in order.
// Depends on plt_pkg and plt_req_if.
`default_nettype none

module plt_ctrl #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned ADDR_W  = 4,
	parameter int unsigned CNT_W   = 5,
	parameter int unsigned ID_W    = 16,
	parameter int unsigned LIFE_W  = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	plt_req_if.sink                req,
	// entry memory
	output logic                   mem_we,
	output logic      [ADDR_W-1:0] mem_waddr,
	output logic      [ID_W-1:0]   mem_wid,
	output logic      [LIFE_W-1:0] mem_wlife,
	output logic                   mem_re,
	output logic      [ADDR_W-1:0] mem_raddr,
	input  wire logic [ID_W-1:0]   mem_rid,
	input  wire logic [LIFE_W-1:0] mem_rlife,
	// result register
	output logic                   emit,
	output plt_pkg::plt_res_t      res,
	input  wire logic              out_free
);
	import plt_pkg::*;

	plt_state_t          state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [CNT_W-1:0]    idx_s1;
	logic                vld_s1;
	logic                hit_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [ID_W-1:0]     id_q;
	logic [STATUS_W-1:0] status_q;
	logic [FIELD_W-1:0]  fid_q;
	logic [LIFE_W-1:0]   flife_q;

	logic                  accept;
	logic                  full;
	logic                  is_scan_cmd;
	logic                  id_match;
	logic                  expired_now;
	logic                  stall;
	logic                  last_s1;
	logic                  hit_now;
	logic                  issue;
	logic                  step_s1;
	logic [ID_W-1:0]       in_id;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign in_id       = req.proc_id[ID_W-1:0];
	assign full        = count_q >= CNT_W'(ENTRIES);
	assign is_scan_cmd = (req.cmd == CMD_DELETE) || (req.cmd == CMD_QUERY)
		|| (req.cmd == CMD_TICK);
	assign accept      = req.valid && req.ready;

	// Stage 1 holds the entry from the last issued read
	assign id_match    = mem_rid == id_q;
	assign expired_now = vld_s1 && (cmd_q == CMD_TICK) && (mem_rlife == '0);
	assign stall       = expired_now && !out_free;
	assign step_s1     = vld_s1 && !stall;
	assign last_s1     = vld_s1 && (CNT_W'(idx_s1 + 1'b1) == count_q);
	assign hit_now     = hit_q || (vld_s1 && id_match);
	assign issue       = (state_q == S_SCAN) && !stall && (rd_idx_q < count_q);

	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q[ADDR_W-1:0];
	assign count_ext = (CNT_W+COUNT_W)'(count_q);

	// Next state, memory writes and result records
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = count_q[ADDR_W-1:0];
		mem_wid   = in_id;
		mem_wlife = req.life_ticks[LIFE_W-1:0];
		emit      = 1'b0;
		res       = '0;
		res.entry_count = count_ext[COUNT_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.cmd == CMD_INSERT && !full) begin
						mem_we = 1'b1;
					end
					if (is_scan_cmd && count_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				mem_wid   = mem_rid;
				mem_wlife = mem_rlife;
				if (step_s1) begin
					if (cmd_q == CMD_TICK) begin
						if (mem_rlife != '0) begin
							// count down in place
							mem_we    = 1'b1;
							mem_waddr = idx_s1[ADDR_W-1:0];
							mem_wlife = LIFE_W'(mem_rlife - 1'b1);
						end else begin
							emit           = 1'b1;
							res.status     = ST_EXPIRED;
							res.found_id   = FIELD_W'(mem_rid);
							res.last       = 1'b0;
						end
					end else if (cmd_q == CMD_DELETE && hit_q) begin
						// close the gap: move each later entry down by one
						mem_we    = 1'b1;
						mem_waddr = ADDR_W'(idx_s1 - 1'b1);
					end
					if (last_s1) begin
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				emit          = 1'b1;
				res.status    = status_q;
				res.found_id  = fid_q;
				res.life_left = FIELD_W'(flife_q);
				res.last      = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control: entry count, scan pointers, match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
		end else if (accept) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
			if (req.cmd == CMD_INSERT && !full) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (req.cmd == CMD_CLEAR) begin
				count_q <= '0;
			end
		end else if (state_q == S_SCAN && !stall) begin
			vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
			end
			if (vld_s1 && id_match) begin
				hit_q <= 1'b1;
			end
			if (last_s1 && cmd_q == CMD_DELETE && hit_now) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	// Payload: command, id, closing result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			id_q    <= in_id;
			fid_q   <= (req.cmd == CMD_QUERY) ? FIELD_W'(in_id) : '0;
			flife_q <= '0;
			if (req.cmd == CMD_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else if (req.cmd == CMD_DELETE || req.cmd == CMD_QUERY) begin
				status_q <= ST_NOT_FOUND;
			end else if (req.cmd == CMD_TICK) begin
				status_q <= ST_TICK_DONE;
			end else begin
				status_q <= ST_OK;
			end
		end else if (state_q == S_SCAN && step_s1) begin
			if (idx_s1 == '0 || !hit_q) begin
				if (cmd_q == CMD_QUERY && !hit_q && id_match) begin
					flife_q <= mem_rlife;
				end
			end
			if (last_s1 && cmd_q != CMD_TICK) begin
				status_q <= hit_now ? ST_OK : ST_NOT_FOUND;
			end
		end
		if (state_q == S_SCAN && stall == 1'b0 && issue) begin
			idx_s1 <= rd_idx_q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/process_lifetime_timer_table_unit.sv -----
// Insert, clear and unused codes go straight to the closing result; delete,
// query and tick walk the entry memory, one entry per cycle except while an
// expired record waits for the output register, and then present their
// closing result. With no entries stored they skip the walk.
// One command at a time; the entry memory has a single read port.
// Reset: the entry count goes to zero, which empties the store at once.
`default_nettype none

module process_lifetime_timer_table_unit #(
	parameter int unsigned ENTRIES   = 16,
	parameter int unsigned ID_BITS   = 16,
	parameter int unsigned LIFE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	plt_req_if.sink   req,
	plt_rsp_if.source rsp
);
	import plt_pkg::*;

	localparam int unsigned ADDR_W = $clog2(ENTRIES);
	localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
	localparam int unsigned ID_W   = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
	localparam int unsigned LIFE_W = (LIFE_BITS < FIELD_W) ? LIFE_BITS : FIELD_W;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ID_W-1:0]   mem_wid;
	logic [LIFE_W-1:0] mem_wlife;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [ID_W-1:0]   mem_rid;
	logic [LIFE_W-1:0] mem_rlife;
	logic              emit;
	plt_res_t          res;
	logic              out_free;

	plt_ctrl #(
		.ENTRIES (ENTRIES),
		.ADDR_W  (ADDR_W),
		.CNT_W   (CNT_W),
		.ID_W    (ID_W),
		.LIFE_W  (LIFE_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wid   (mem_wid),
		.mem_wlife (mem_wlife),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rid   (mem_rid),
		.mem_rlife (mem_rlife),
		.emit      (emit),
		.res       (res),
		.out_free  (out_free)
	);

	plt_mem #(
		.DEPTH  (ENTRIES),
		.ADDR_W (ADDR_W),
		.ID_W   (ID_W),
		.LIFE_W (LIFE_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wid   (mem_wid),
		.wlife (mem_wlife),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rid   (mem_rid),
		.rlife (mem_rlife)
	);

	plt_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.res      (res),
		.out_free (out_free),
		.rsp      (rsp)
	);

`ifndef SYNTHESIS
	// An expired record never closes a command
	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EXPIRED |-> !rsp.last)
		else $error("expired record marked last");

	// The tick closing record carries no id
	a_tick_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_TICK_DONE |-> rsp.last && rsp.found_id == '0)
		else $error("malformed tick done record");

	// One command at a time: busy right after a transfer
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command taken while busy");
`endif

endmodule

`default_nettype wire
